### hw/rtl/servo_angle_line_parser_assert.svh
// Assertion macros used by the servo angle line parser checker.
`ifndef SERVO_ANGLE_LINE_PARSER_ASSERT_SVH
`define SERVO_ANGLE_LINE_PARSER_ASSERT_SVH

// Clocked assertion, disabled while reset is held.
`define SAL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("servo angle line parser assertion failed");

// Clocked assertion that is also checked during reset.
`define SAL_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("servo angle line parser reset assertion failed");

`endif

### hw/rtl/sal_pkg.sv
// Shared types and constants of the servo angle line parser.
`timescale 1ns / 1ps
`default_nettype none

package sal_pkg;

    // Character codes
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // Request kinds on the input tuser
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Result status on the output tuser
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_ANGLE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ANGLE     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

    // Register reset values
    localparam logic [7:0]  MIN_ANGLE_RST     = 8'd10;
    localparam logic [7:0]  MAX_ANGLE_RST     = 8'd170;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

    // Servo angles
    localparam int NUM_ANGLES = 6;
    localparam int NUM_PEND   = NUM_ANGLES - 1;
    localparam int ANGLE_W    = 8;
    localparam logic [NUM_ANGLES-1:0][ANGLE_W-1:0] ANGLE_RST =
        {8'd90, 8'd90, 8'd170, 8'd110, 8'd115, 8'd90};

    // Token queue depth default (two or more)
    localparam int QUEUE_DEPTH_DEF = 4;

    // Classified input token
    typedef enum logic [2:0] {
        TK_DIGIT,
        TK_COMMA,
        TK_NL,
        TK_CR,
        TK_BAD,
        TK_TICK
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind  kind;
        logic [3:0] digit;
    } t_tok;

endpackage

`default_nettype wire

### hw/rtl/servo_angle_line_parser.sv
// Top level of the servo angle line parser.
//
//  Channel  Direction  Handshake                     Payload
//  s_axis   in         s_axis_tvalid/s_axis_tready   tdata rx_byte, tuser req_type
//  m_axis   out        m_axis_tvalid/m_axis_tready   tdata angle_0..5, tuser status
//  cfg      in         i_cfg_valid/o_cfg_ready       i_cfg_addr, i_cfg_data
//
//  One item per cycle is sustained while the queue has room; the back end parser step
//  takes one token a cycle while its result register is free or being drained.
//  Up to QUEUE_DEPTH tokens are buffered, so input keeps flowing while a result waits.
//  Input is held off until reset has released; reset is synchronous, active low.
//  Configuration writes are taken in every cycle.
`timescale 1ns / 1ps
`default_nettype none

module servo_angle_line_parser #(
    parameter int QUEUE_DEPTH = sal_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                           s_axis_tuser,  // [0] req_type
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [7:0] angle_0, [15:8] angle_1, ... [47:40] angle_5
    output logic [sal_pkg::NUM_ANGLES*sal_pkg::ANGLE_W-1:0] m_axis_tdata,
    output logic                                m_axis_tuser,  // [0] status
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [sal_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [sal_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic          q_ready;
    logic          q_push;
    sal_pkg::t_tok front_tok;
    logic          q_valid;
    sal_pkg::t_tok q_tok;
    logic          q_pop;

    assign o_cfg_ready = 1'b1;

    sal_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_q_ready  (q_ready),
        .o_push     (q_push),
        .o_tok      (front_tok)
    );

    sal_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_tok   (front_tok),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_tok   (q_tok),
        .i_pop   (q_pop)
    );

    sal_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_tok_valid (q_valid),
        .i_tok       (q_tok),
        .o_tok_pop   (q_pop),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

endmodule

`default_nettype wire

### hw/rtl/sal_front.sv
// Front end: accepts input transfers and classifies each into a token.
`timescale 1ns / 1ps
`default_nettype none

module sal_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [7:0]    i_s_tdata,   // [7:0] rx_byte
    input  wire logic          i_s_tuser,   // [0] req_type
    input  wire logic          i_q_ready,
    output logic               o_push,
    output sal_pkg::t_tok      o_tok
);

    logic r_rst_done;

    // Hold off input until reset has released
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rst_done <= 1'b0;
        end else begin
            r_rst_done <= 1'b1;
        end
    end

    assign o_s_tready = i_q_ready && r_rst_done;
    assign o_push     = i_s_tvalid && o_s_tready;

    // Classify the byte or tick
    always_comb begin
        o_tok.digit = 4'(i_s_tdata - sal_pkg::CHAR_0);
        if (i_s_tuser == sal_pkg::REQ_TICK) begin
            o_tok.kind = sal_pkg::TK_TICK;
        end else if (i_s_tdata inside {[sal_pkg::CHAR_0:sal_pkg::CHAR_9]}) begin
            o_tok.kind = sal_pkg::TK_DIGIT;
        end else if (i_s_tdata == sal_pkg::CHAR_COMMA) begin
            o_tok.kind = sal_pkg::TK_COMMA;
        end else if (i_s_tdata == sal_pkg::CHAR_NL) begin
            o_tok.kind = sal_pkg::TK_NL;
        end else if (i_s_tdata == sal_pkg::CHAR_CR) begin
            o_tok.kind = sal_pkg::TK_CR;
        end else begin
            o_tok.kind = sal_pkg::TK_BAD;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sal_queue.sv
// Short token queue between the front end and the parser back end.
`timescale 1ns / 1ps
`default_nettype none

module sal_queue #(
    parameter int QUEUE_DEPTH = sal_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sal_pkg::t_tok i_tok,
    output logic               o_ready,
    output logic               o_valid,
    output sal_pkg::t_tok      o_tok,
    input  wire logic          i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    sal_pkg::t_tok    r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_tok   = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed tokens
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_tok;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sal_back.sv
// Back end: line parser state, configuration registers and result register.
`timescale 1ns / 1ps
`default_nettype none

module sal_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [sal_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [sal_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_tok_valid,
    input  wire sal_pkg::t_tok                    i_tok,
    output logic                                  o_tok_pop,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [sal_pkg::NUM_ANGLES*sal_pkg::ANGLE_W-1:0] o_m_tdata,
    output logic                                  o_m_tuser
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LINE,
        PH_DISCARD
    } t_phase;

    localparam logic [2:0] LAST_FIELD = 3'(sal_pkg::NUM_PEND);

    // Configuration
    logic [7:0]  r_min_angle;
    logic [7:0]  r_max_angle;
    logic [15:0] r_timeout;

    // Parser state
    t_phase      r_phase, n_phase;
    logic [2:0]  r_field, n_field;
    logic [7:0]  r_acc, n_acc;
    logic        r_seen, n_seen;
    logic [15:0] r_timer, n_timer;
    logic [sal_pkg::NUM_PEND-1:0][7:0]   r_pend;
    logic [sal_pkg::NUM_ANGLES-1:0][7:0] r_applied, n_applied;

    // Result register
    logic        r_m_valid;
    logic        r_m_status;
    logic [sal_pkg::NUM_ANGLES-1:0][7:0] r_m_angles;

    // Step signals
    logic        pend_we;
    logic [2:0]  pend_idx;
    logic        res_valid;
    logic        res_status;
    logic        line_start;
    logic [2:0]  cur_field;
    logic [7:0]  cur_acc;
    logic        cur_seen;
    logic [11:0] acc_sum;
    logic        all_in_range;

    function automatic logic in_range(input logic [7:0] v, input logic [7:0] lo,
                                      input logic [7:0] hi);
        in_range = (v >= lo) && (v <= hi);
    endfunction

    // Take a token whenever the result register is free or being drained
    assign o_tok_pop = i_tok_valid && (!r_m_valid || i_m_tready);

    assign line_start = (r_phase != PH_LINE);
    assign cur_field  = line_start ? 3'd0 : r_field;
    assign cur_acc    = line_start ? 8'd0 : r_acc;
    assign cur_seen   = line_start ? 1'b0 : r_seen;
    assign acc_sum    = {4'd0, cur_acc} * 12'd10 + {8'd0, i_tok.digit};

    // Check all six fields of the finished line
    always_comb begin
        all_in_range = in_range(cur_acc, r_min_angle, r_max_angle);
        for (int i = 0; i < sal_pkg::NUM_PEND; i++) begin
            if (!in_range(r_pend[i], r_min_angle, r_max_angle)) begin
                all_in_range = 1'b0;
            end
        end
    end

    // Parse one token
    always_comb begin
        n_phase    = r_phase;
        n_field    = r_field;
        n_acc      = r_acc;
        n_seen     = r_seen;
        n_timer    = r_timer;
        n_applied  = r_applied;
        pend_we    = 1'b0;
        pend_idx   = cur_field;
        res_valid  = 1'b0;
        res_status = sal_pkg::ST_OK;
        if (o_tok_pop) begin
            if (i_tok.kind == sal_pkg::TK_TICK) begin
                if (r_phase == PH_LINE) begin
                    if (r_timer >= r_timeout) begin
                        n_phase    = PH_DISCARD;
                        res_valid  = 1'b1;
                        res_status = sal_pkg::ST_ERR;
                    end else begin
                        n_timer = r_timer + 16'd1;
                    end
                end
            end else if (r_phase == PH_DISCARD) begin
                if (i_tok.kind == sal_pkg::TK_NL) begin
                    n_phase = PH_IDLE;
                end
            end else if (line_start && (i_tok.kind == sal_pkg::TK_NL ||
                                        i_tok.kind == sal_pkg::TK_CR)) begin
                // skip blank lines and stray carriage returns
                n_phase = PH_IDLE;
            end else begin
                n_phase = PH_LINE;
                n_field = cur_field;
                n_acc   = cur_acc;
                n_seen  = cur_seen;
                if (line_start) begin
                    n_timer = 16'd0;
                end
                case (i_tok.kind)
                    sal_pkg::TK_NL: begin
                        n_phase   = PH_IDLE;
                        res_valid = 1'b1;
                        if (cur_seen && cur_field == LAST_FIELD && all_in_range) begin
                            for (int i = 0; i < sal_pkg::NUM_PEND; i++) begin
                                n_applied[i] = r_pend[i];
                            end
                            n_applied[sal_pkg::NUM_ANGLES-1] = cur_acc;
                            res_status = sal_pkg::ST_OK;
                        end else begin
                            res_status = sal_pkg::ST_ERR;
                        end
                    end
                    sal_pkg::TK_CR: begin
                    end
                    sal_pkg::TK_DIGIT: begin
                        n_acc  = (acc_sum > 12'd255) ? 8'd255 : acc_sum[7:0];
                        n_seen = 1'b1;
                    end
                    sal_pkg::TK_COMMA: begin
                        if (!cur_seen || cur_field >= LAST_FIELD) begin
                            n_phase    = PH_DISCARD;
                            res_valid  = 1'b1;
                            res_status = sal_pkg::ST_ERR;
                        end else begin
                            pend_we = 1'b1;
                            n_field = cur_field + 3'd1;
                            n_acc   = 8'd0;
                            n_seen  = 1'b0;
                        end
                    end
                    default: begin
                        // bad character: drop the rest of the line
                        n_phase    = PH_DISCARD;
                        res_valid  = 1'b1;
                        res_status = sal_pkg::ST_ERR;
                    end
                endcase
            end
        end
    end

    // Hold control state, configuration and the result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_field     <= 3'd0;
            r_acc       <= 8'd0;
            r_seen      <= 1'b0;
            r_timer     <= 16'd0;
            r_applied   <= sal_pkg::ANGLE_RST;
            r_min_angle <= sal_pkg::MIN_ANGLE_RST;
            r_max_angle <= sal_pkg::MAX_ANGLE_RST;
            r_timeout   <= sal_pkg::TIMEOUT_TICKS_RST;
            r_m_valid   <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_field   <= n_field;
            r_acc     <= n_acc;
            r_seen    <= n_seen;
            r_timer   <= n_timer;
            r_applied <= n_applied;
            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    sal_pkg::REG_MIN_ANGLE:     r_min_angle <= i_cfg_data[7:0];
                    sal_pkg::REG_MAX_ANGLE:     r_max_angle <= i_cfg_data[7:0];
                    sal_pkg::REG_TIMEOUT_TICKS: r_timeout   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (res_valid) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Store completed fields and the result payload
    always_ff @(posedge i_clk) begin
        if (pend_we) begin
            r_pend[pend_idx] <= r_acc;
        end
        if (res_valid) begin
            r_m_status <= res_status;
            r_m_angles <= n_applied;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_status;
    assign o_m_tdata  = r_m_angles;

endmodule

`default_nettype wire

### hw/rtl/sal_checker.sv
// Port-level assertions of the servo angle line parser and their bind.
`timescale 1ns / 1ps
`default_nettype none
`include "servo_angle_line_parser_assert.svh"

module sal_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic [sal_pkg::NUM_ANGLES*sal_pkg::ANGLE_W-1:0] m_axis_tdata,
    input wire logic m_axis_tuser
);

    logic [sal_pkg::NUM_ANGLES*sal_pkg::ANGLE_W-1:0] r_last_angles;

    // Track the angles of the last result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angles <= sal_pkg::ANGLE_RST;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_last_angles <= m_axis_tdata;
        end
    end

    // A stalled result holds its payload
    `SAL_ASSERT(a_out_hold, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))

    // A rejected line leaves the held angles as they were
    `SAL_ASSERT(a_err_keeps_angles, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tready && m_axis_tuser == sal_pkg::ST_ERR) |-> (m_axis_tdata == r_last_angles))

    // Input backs up only behind a waiting result
    `SAL_ASSERT(a_stall_cause, i_clk, i_rst_n,
        (!s_axis_tready && $past(i_rst_n)) |-> m_axis_tvalid)

    // No result right after reset
    `SAL_ASSERT_RST(a_reset_idle, i_clk,
        !i_rst_n |=> !m_axis_tvalid)

endmodule

bind servo_angle_line_parser sal_checker u_sal_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
